// File: rtl/core/ptle_pkg.sv
`default_nettype none
// ---------------------------------------------------------------------------
// ptle_pkg
// Shared types and default sizes for the point triangle locate and error
// pipeline.
// ---------------------------------------------------------------------------
package ptle_pkg;

	localparam int PTLE_COORD_WIDTH = 12;
	localparam int PTLE_ELEV_WIDTH  = 32;
	localparam int PTLE_DIV_STEPS   = 4;

	typedef enum logic [2:0] {
		LOC_OUTSIDE  = 3'd0,
		LOC_INTERIOR = 3'd1,
		LOC_EDGE_AB  = 3'd2,
		LOC_EDGE_BC  = 3'd3,
		LOC_EDGE_CA  = 3'd4
	} loc_t;

	// Travels with the quotient through the divider.
	typedef struct packed {
		loc_t loc;
		logic degen;
		logic qneg;
	} ctl_t;

	// Status part of one result.
	typedef struct packed {
		loc_t loc;
		logic degen;
		logic sat;
	} res_flags_t;

endpackage
`default_nettype wire

// File: rtl/core/ptle_front.sv
`default_nettype none
// ---------------------------------------------------------------------------
// ptle_front
// Five pipeline stages: coordinate differences, cross products and the
// plane denominator, location class and elevation products, the numerator
// sum, and the sign and magnitude split ahead of the divider.
// ---------------------------------------------------------------------------
module ptle_front import ptle_pkg::*; #(
	parameter int COORD_WIDTH = PTLE_COORD_WIDTH,
	parameter int ELEV_WIDTH  = PTLE_ELEV_WIDTH
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         adv,
	input  logic                         in_valid,
	input  logic [COORD_WIDTH-1:0]       point_col,
	input  logic [COORD_WIDTH-1:0]       point_row,
	input  logic signed [ELEV_WIDTH-1:0] point_elev,
	input  logic [COORD_WIDTH-1:0]       vertex_a_col,
	input  logic [COORD_WIDTH-1:0]       vertex_a_row,
	input  logic signed [ELEV_WIDTH-1:0] vertex_a_elev,
	input  logic [COORD_WIDTH-1:0]       vertex_b_col,
	input  logic [COORD_WIDTH-1:0]       vertex_b_row,
	input  logic signed [ELEV_WIDTH-1:0] vertex_b_elev,
	input  logic [COORD_WIDTH-1:0]       vertex_c_col,
	input  logic [COORD_WIDTH-1:0]       vertex_c_row,
	input  logic signed [ELEV_WIDTH-1:0] vertex_c_elev,
	output logic                         out_valid,
	output logic [ELEV_WIDTH+2*COORD_WIDTH+4:0] out_num,
	output logic [2*COORD_WIDTH+2:0]     out_den,
	output ctl_t                         out_ctl,
	output logic signed [ELEV_WIDTH-1:0] out_az,
	output logic signed [ELEV_WIDTH-1:0] out_pz
);

	localparam int DW = COORD_WIDTH + 1;
	localparam int PW = 2 * COORD_WIDTH + 3;
	localparam int ZW = ELEV_WIDTH + 1;
	localparam int MW = ZW + PW;
	localparam int SW = MW + 1;

	logic                         v_s1;
	logic signed [DW-1:0]         v1x_s1, v1y_s1, v2x_s1, v2y_s1, dx_s1, dy_s1;
	logic signed [DW-1:0]         wx_s1, wy_s1, pbx_s1, pby_s1;
	logic signed [DW-1:0]         ux_s1, uy_s1, pcx_s1, pcy_s1;
	logic signed [ZW-1:0]         v1z_s1, v2z_s1;
	logic signed [ELEV_WIDTH-1:0] az_s1, pz_s1;
	logic [2:0]                   box_s1;

	logic                         v_s2;
	logic signed [PW-1:0]         cr1_s2, cr2_s2, cr3_s2, k_s2, c1_s2, c2_s2;
	logic signed [ZW-1:0]         v1z_s2, v2z_s2;
	logic signed [ELEV_WIDTH-1:0] az_s2, pz_s2;
	logic [2:0]                   box_s2;

	logic                         v_s3;
	logic signed [MW-1:0]         p1_s3, p2_s3;
	logic signed [PW-1:0]         k_s3;
	loc_t                         loc_s3;
	logic                         degen_s3;
	logic signed [ELEV_WIDTH-1:0] az_s3, pz_s3;

	logic                         v_s4;
	logic signed [SW-1:0]         sum_s4;
	logic signed [PW-1:0]         k_s4;
	loc_t                         loc_s4;
	logic                         degen_s4;
	logic signed [ELEV_WIDTH-1:0] az_s4, pz_s4;

	logic                         v_s5;
	logic [SW-1:0]                num_s5;
	logic [PW-1:0]                den_s5;
	ctl_t                         ctl_s5;
	logic signed [ELEV_WIDTH-1:0] az_s5, pz_s5;

	logic [2:0] box_d;
	logic       z1, z2, z3, pos1, pos2, pos3;
	loc_t       loc_d;
	logic       sneg, kneg;

	function automatic logic between(input logic [COORD_WIDTH-1:0] p,
		input logic [COORD_WIDTH-1:0] u, input logic [COORD_WIDTH-1:0] v);
		between = (p >= u && p <= v) || (p >= v && p <= u);
	endfunction

	assign box_d[0] = between(point_col, vertex_a_col, vertex_b_col) &&
		between(point_row, vertex_a_row, vertex_b_row);
	assign box_d[1] = between(point_col, vertex_b_col, vertex_c_col) &&
		between(point_row, vertex_b_row, vertex_c_row);
	assign box_d[2] = between(point_col, vertex_c_col, vertex_a_col) &&
		between(point_row, vertex_c_row, vertex_a_row);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else if (adv) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			v1x_s1 <= $signed({1'b0, vertex_b_col}) - $signed({1'b0, vertex_a_col});
			v1y_s1 <= $signed({1'b0, vertex_b_row}) - $signed({1'b0, vertex_a_row});
			v2x_s1 <= $signed({1'b0, vertex_c_col}) - $signed({1'b0, vertex_a_col});
			v2y_s1 <= $signed({1'b0, vertex_c_row}) - $signed({1'b0, vertex_a_row});
			dx_s1  <= $signed({1'b0, point_col}) - $signed({1'b0, vertex_a_col});
			dy_s1  <= $signed({1'b0, point_row}) - $signed({1'b0, vertex_a_row});
			wx_s1  <= $signed({1'b0, vertex_c_col}) - $signed({1'b0, vertex_b_col});
			wy_s1  <= $signed({1'b0, vertex_c_row}) - $signed({1'b0, vertex_b_row});
			pbx_s1 <= $signed({1'b0, point_col}) - $signed({1'b0, vertex_b_col});
			pby_s1 <= $signed({1'b0, point_row}) - $signed({1'b0, vertex_b_row});
			ux_s1  <= $signed({1'b0, vertex_a_col}) - $signed({1'b0, vertex_c_col});
			uy_s1  <= $signed({1'b0, vertex_a_row}) - $signed({1'b0, vertex_c_row});
			pcx_s1 <= $signed({1'b0, point_col}) - $signed({1'b0, vertex_c_col});
			pcy_s1 <= $signed({1'b0, point_row}) - $signed({1'b0, vertex_c_row});
			v1z_s1 <= ZW'(vertex_b_elev) - ZW'(vertex_a_elev);
			v2z_s1 <= ZW'(vertex_c_elev) - ZW'(vertex_a_elev);
			az_s1  <= vertex_a_elev;
			pz_s1  <= point_elev;
			box_s1 <= box_d;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			cr1_s2 <= PW'(v1x_s1 * dy_s1) - PW'(dx_s1 * v1y_s1);
			cr2_s2 <= PW'(wx_s1 * pby_s1) - PW'(pbx_s1 * wy_s1);
			cr3_s2 <= PW'(ux_s1 * pcy_s1) - PW'(pcx_s1 * uy_s1);
			k_s2   <= PW'(v1x_s1 * v2y_s1) - PW'(v1y_s1 * v2x_s1);
			c1_s2  <= PW'(v1y_s1 * dx_s1) - PW'(v1x_s1 * dy_s1);
			c2_s2  <= PW'(v2x_s1 * dy_s1) - PW'(v2y_s1 * dx_s1);
			v1z_s2 <= v1z_s1;
			v2z_s2 <= v2z_s1;
			az_s2  <= az_s1;
			pz_s2  <= pz_s1;
			box_s2 <= box_s1;
		end
	end

	always_comb begin
		z1   = (cr1_s2 == '0);
		z2   = (cr2_s2 == '0);
		z3   = (cr3_s2 == '0);
		pos1 = !cr1_s2[PW-1] && !z1;
		pos2 = !cr2_s2[PW-1] && !z2;
		pos3 = !cr3_s2[PW-1] && !z3;
		if (!z1 && !z2 && !z3 && pos1 == pos2 && pos2 == pos3) begin
			loc_d = LOC_INTERIOR;
		end else if (z1 && box_s2[0]) begin
			loc_d = LOC_EDGE_AB;
		end else if (z2 && box_s2[1]) begin
			loc_d = LOC_EDGE_BC;
		end else if (z3 && box_s2[2]) begin
			loc_d = LOC_EDGE_CA;
		end else begin
			loc_d = LOC_OUTSIDE;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			p1_s3    <= MW'(v2z_s2 * c1_s2);
			p2_s3    <= MW'(v1z_s2 * c2_s2);
			k_s3     <= k_s2;
			loc_s3   <= loc_d;
			degen_s3 <= (k_s2 == '0);
			az_s3    <= az_s2;
			pz_s3    <= pz_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			sum_s4   <= SW'(p1_s3) + SW'(p2_s3);
			k_s4     <= k_s3;
			loc_s4   <= loc_s3;
			degen_s4 <= degen_s3;
			az_s4    <= az_s3;
			pz_s4    <= pz_s3;
		end
	end

	assign sneg = sum_s4[SW-1];
	assign kneg = k_s4[PW-1];

	always_ff @(posedge clk) begin
		if (adv) begin
			num_s5       <= sneg ? SW'(-sum_s4) : SW'(sum_s4);
			den_s5       <= kneg ? PW'(-k_s4) : PW'(k_s4);
			ctl_s5.loc   <= loc_s4;
			ctl_s5.degen <= degen_s4;
			ctl_s5.qneg  <= (sneg == kneg);
			az_s5        <= az_s4;
			pz_s5        <= pz_s4;
		end
	end

	assign out_valid = v_s5;
	assign out_num   = num_s5;
	assign out_den   = den_s5;
	assign out_ctl   = ctl_s5;
	assign out_az    = az_s5;
	assign out_pz    = pz_s5;

endmodule
`default_nettype wire

// File: rtl/core/ptle_div.sv
`default_nettype none
// ---------------------------------------------------------------------------
// ptle_div
// Pipelined restoring divider. Each stage resolves up to STEPS quotient
// bits, most significant first, and carries its item's side information.
// ---------------------------------------------------------------------------
module ptle_div import ptle_pkg::*; #(
	parameter int NUM_WIDTH  = PTLE_ELEV_WIDTH + 2 * PTLE_COORD_WIDTH + 5,
	parameter int DEN_WIDTH  = 2 * PTLE_COORD_WIDTH + 3,
	parameter int ELEV_WIDTH = PTLE_ELEV_WIDTH,
	parameter int STEPS      = PTLE_DIV_STEPS
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         adv,
	input  logic                         in_valid,
	input  logic [NUM_WIDTH-1:0]         in_num,
	input  logic [DEN_WIDTH-1:0]         in_den,
	input  ctl_t                         in_ctl,
	input  logic signed [ELEV_WIDTH-1:0] in_az,
	input  logic signed [ELEV_WIDTH-1:0] in_pz,
	output logic                         out_valid,
	output logic [NUM_WIDTH-1:0]         out_quo,
	output ctl_t                         out_ctl,
	output logic signed [ELEV_WIDTH-1:0] out_az,
	output logic signed [ELEV_WIDTH-1:0] out_pz
);

	localparam int NST = (NUM_WIDTH + STEPS - 1) / STEPS;

	logic                         v_s   [NST];
	logic [DEN_WIDTH-1:0]         rem_s [NST];
	logic [NUM_WIDTH-1:0]         quo_s [NST];
	logic [DEN_WIDTH-1:0]         den_s [NST];
	ctl_t                         ctl_s [NST];
	logic signed [ELEV_WIDTH-1:0] az_s  [NST];
	logic signed [ELEV_WIDTH-1:0] pz_s  [NST];

	for (genvar st = 0; st < NST; st++) begin : g_stage
		logic                         v_in;
		logic [DEN_WIDTH-1:0]         rem_in, rem_nx, den_in;
		logic [NUM_WIDTH-1:0]         quo_in, quo_nx;
		ctl_t                         ctl_in;
		logic signed [ELEV_WIDTH-1:0] az_in, pz_in;

		if (st == 0) begin : g_first
			assign v_in   = in_valid;
			assign rem_in = '0;
			assign quo_in = in_num;
			assign den_in = in_den;
			assign ctl_in = in_ctl;
			assign az_in  = in_az;
			assign pz_in  = in_pz;
		end else begin : g_next
			assign v_in   = v_s[st-1];
			assign rem_in = rem_s[st-1];
			assign quo_in = quo_s[st-1];
			assign den_in = den_s[st-1];
			assign ctl_in = ctl_s[st-1];
			assign az_in  = az_s[st-1];
			assign pz_in  = pz_s[st-1];
		end

		always_comb begin
			logic [DEN_WIDTH:0]   t;
			logic [DEN_WIDTH-1:0] r;
			logic [NUM_WIDTH-1:0] w;
			r = rem_in;
			w = quo_in;
			t = '0;
			for (int j = 0; j < STEPS; j++) begin
				if (st * STEPS + j < NUM_WIDTH) begin
					t = {r, w[NUM_WIDTH-1]};
					w = w << 1;
					if (t >= {1'b0, den_in}) begin
						t    = t - {1'b0, den_in};
						w[0] = 1'b1;
					end
					r = t[DEN_WIDTH-1:0];
				end
			end
			rem_nx = r;
			quo_nx = w;
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[st] <= 1'b0;
			end else if (adv) begin
				v_s[st] <= v_in;
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				rem_s[st] <= rem_nx;
				quo_s[st] <= quo_nx;
				den_s[st] <= den_in;
				ctl_s[st] <= ctl_in;
				az_s[st]  <= az_in;
				pz_s[st]  <= pz_in;
			end
		end
	end

	assign out_valid = v_s[NST-1];
	assign out_quo   = quo_s[NST-1];
	assign out_ctl   = ctl_s[NST-1];
	assign out_az    = az_s[NST-1];
	assign out_pz    = pz_s[NST-1];

endmodule
`default_nettype wire

// File: rtl/core/ptle_back.sv
`default_nettype none
// ---------------------------------------------------------------------------
// ptle_back
// Four pipeline stages after the divider: quotient cap and sign, vertex a
// offset, estimate saturation and difference, then error magnitude and the
// final result flags.
// ---------------------------------------------------------------------------
module ptle_back import ptle_pkg::*; #(
	parameter int NUM_WIDTH  = PTLE_ELEV_WIDTH + 2 * PTLE_COORD_WIDTH + 5,
	parameter int ELEV_WIDTH = PTLE_ELEV_WIDTH
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         adv,
	input  logic                         in_valid,
	input  logic [NUM_WIDTH-1:0]         in_quo,
	input  ctl_t                         in_ctl,
	input  logic signed [ELEV_WIDTH-1:0] in_az,
	input  logic signed [ELEV_WIDTH-1:0] in_pz,
	output logic                         out_valid,
	output res_flags_t                   out_flags,
	output logic signed [ELEV_WIDTH-1:0] out_est,
	output logic [ELEV_WIDTH-2:0]        out_err
);

	localparam int            QW   = 63;
	localparam int            FW   = 65;
	localparam int            DFW  = 66;
	localparam logic [QW-1:0] QCAP = QW'(1) << 62;
	localparam logic signed [ELEV_WIDTH-1:0] EST_MAX = {1'b0, {(ELEV_WIDTH-1){1'b1}}};
	localparam logic signed [ELEV_WIDTH-1:0] EST_MIN = {1'b1, {(ELEV_WIDTH-1){1'b0}}};

	logic                         v_s1, v_s2, v_s3, v_s4;
	logic signed [QW:0]           qv_s1;
	ctl_t                         ctl_s1, ctl_s2, ctl_s3;
	logic signed [ELEV_WIDTH-1:0] az_s1, pz_s1, pz_s2;
	logic signed [FW-1:0]         full_s2;
	logic signed [DFW-1:0]        diff_s3;
	logic signed [ELEV_WIDTH-1:0] est_s3, est_s4;
	logic                         est_sat_s3;
	res_flags_t                   flags_s4;
	logic [ELEV_WIDTH-2:0]        err_s4;

	logic [QW-1:0]   capped;
	logic            in_range;
	logic [DFW-1:0]  ad;
	logic            clip;

	assign capped = (|(in_quo >> 62)) ? QCAP : QW'(in_quo);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (adv) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			qv_s1  <= in_ctl.qneg ? -$signed({1'b0, capped}) : $signed({1'b0, capped});
			ctl_s1 <= in_ctl;
			az_s1  <= in_az;
			pz_s1  <= in_pz;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			full_s2 <= FW'(qv_s1) + FW'(az_s1);
			ctl_s2  <= ctl_s1;
			pz_s2   <= pz_s1;
		end
	end

	assign in_range = (&full_s2[FW-1:ELEV_WIDTH-1]) || !(|full_s2[FW-1:ELEV_WIDTH-1]);

	always_ff @(posedge clk) begin
		if (adv) begin
			diff_s3    <= DFW'(full_s2) - DFW'(pz_s2);
			est_sat_s3 <= !in_range;
			if (in_range) begin
				est_s3 <= full_s2[ELEV_WIDTH-1:0];
			end else begin
				est_s3 <= full_s2[FW-1] ? EST_MIN : EST_MAX;
			end
			ctl_s3 <= ctl_s2;
		end
	end

	assign ad   = diff_s3[DFW-1] ? DFW'(-diff_s3) : DFW'(diff_s3);
	assign clip = |ad[DFW-1:ELEV_WIDTH-1];

	always_ff @(posedge clk) begin
		if (adv) begin
			flags_s4.loc   <= ctl_s3.loc;
			flags_s4.degen <= ctl_s3.degen;
			if (ctl_s3.degen) begin
				est_s4       <= '0;
				err_s4       <= '0;
				flags_s4.sat <= 1'b0;
			end else if (ctl_s3.loc == LOC_OUTSIDE) begin
				est_s4       <= est_s3;
				err_s4       <= '0;
				flags_s4.sat <= est_sat_s3;
			end else begin
				est_s4       <= est_s3;
				err_s4       <= clip ? '1 : ad[ELEV_WIDTH-2:0];
				flags_s4.sat <= est_sat_s3 || clip;
			end
		end
	end

	assign out_valid = v_s4;
	assign out_flags = flags_s4;
	assign out_est   = est_s4;
	assign out_err   = err_s4;

	a_degen_zero: assert property (@(posedge clk) disable iff (!arst_n)
		v_s4 && flags_s4.degen |-> est_s4 == '0 && err_s4 == '0 && !flags_s4.sat)
		else $error("degenerate result with nonzero estimate, error or saturation");

	a_outside_no_err: assert property (@(posedge clk) disable iff (!arst_n)
		v_s4 && flags_s4.loc == LOC_OUTSIDE |-> err_s4 == '0)
		else $error("outside point reports a nonzero error");

	a_sat_cause: assert property (@(posedge clk) disable iff (!arst_n)
		v_s4 && flags_s4.sat |-> est_s4 == EST_MAX || est_s4 == EST_MIN || err_s4 == '1)
		else $error("saturation flag without a clipped value");

endmodule
`default_nettype wire

// File: rtl/core/ptle_outbuf.sv
`default_nettype none
// ---------------------------------------------------------------------------
// ptle_outbuf
// Output register with one skid entry. The pipeline advances while the skid
// entry is empty, so the stall toward the pipeline is a register.
// ---------------------------------------------------------------------------
module ptle_outbuf import ptle_pkg::*; #(
	parameter int ELEV_WIDTH = PTLE_ELEV_WIDTH
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	input  res_flags_t                   in_flags,
	input  logic signed [ELEV_WIDTH-1:0] in_est,
	input  logic [ELEV_WIDTH-2:0]        in_err,
	output logic                         adv,
	output logic                         out_valid,
	input  logic                         out_stall,
	output res_flags_t                   out_flags,
	output logic signed [ELEV_WIDTH-1:0] out_est,
	output logic [ELEV_WIDTH-2:0]        out_err
);

	logic                         out_valid_q, skid_valid_q;
	res_flags_t                   out_flags_q, skid_flags_q;
	logic signed [ELEV_WIDTH-1:0] out_est_q, skid_est_q;
	logic [ELEV_WIDTH-2:0]        out_err_q, skid_err_q;
	logic                         take, push, load_out, load_skid;

	assign adv       = !skid_valid_q;
	assign take      = out_valid_q && !out_stall;
	assign push      = adv && in_valid;
	assign load_out  = push && (!out_valid_q || take);
	assign load_skid = push && out_valid_q && !take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else begin
			if (skid_valid_q) begin
				if (take) begin
					skid_valid_q <= 1'b0;
				end
			end else if (load_skid) begin
				skid_valid_q <= 1'b1;
			end else if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (take) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (skid_valid_q && take) begin
			out_flags_q <= skid_flags_q;
			out_est_q   <= skid_est_q;
			out_err_q   <= skid_err_q;
		end else if (load_out) begin
			out_flags_q <= in_flags;
			out_est_q   <= in_est;
			out_err_q   <= in_err;
		end
		if (load_skid) begin
			skid_flags_q <= in_flags;
			skid_est_q   <= in_est;
			skid_err_q   <= in_err;
		end
	end

	assign out_valid = out_valid_q;
	assign out_flags = out_flags_q;
	assign out_est   = out_est_q;
	assign out_err   = out_err_q;

	a_skid_needs_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> out_valid_q)
		else $error("skid entry holds a transaction while the output register is empty");

	a_skid_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(skid_valid_q) |-> $past(out_valid_q && out_stall))
		else $error("skid entry filled without a stalled output");

	a_no_push_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q && !take |=> skid_valid_q && $stable(skid_est_q))
		else $error("skid entry changed while the output stayed stalled");

endmodule
`default_nettype wire

// File: rtl/core/point_triangle_locate_and_error_top.sv
`default_nettype none
// ---------------------------------------------------------------------------
// point_triangle_locate_and_error_top
// Locates a grid point against a triangle and reports the plane-interpolated
// elevation at the point and its absolute error.
// ---------------------------------------------------------------------------
// The block takes one transaction per cycle while in_stall is low and returns
// exactly one result per transaction, in order. Each transaction passes
// through five stages of geometry and products, the pipelined divider that
// resolves up to STEPS quotient bits per stage, four stages of offset,
// saturation and error, and the output register. A stalled output is
// absorbed by one skid entry; in_stall rises only once that entry is full,
// and the whole pipeline then holds until the output is taken again.
// ---------------------------------------------------------------------------
module point_triangle_locate_and_error_top import ptle_pkg::*; #(
	parameter int COORD_WIDTH = PTLE_COORD_WIDTH,
	parameter int ELEV_WIDTH  = PTLE_ELEV_WIDTH,
	parameter int STEPS       = PTLE_DIV_STEPS
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic [COORD_WIDTH-1:0]       point_col,
	input  logic [COORD_WIDTH-1:0]       point_row,
	input  logic signed [ELEV_WIDTH-1:0] point_elev,
	input  logic [COORD_WIDTH-1:0]       vertex_a_col,
	input  logic [COORD_WIDTH-1:0]       vertex_a_row,
	input  logic signed [ELEV_WIDTH-1:0] vertex_a_elev,
	input  logic [COORD_WIDTH-1:0]       vertex_b_col,
	input  logic [COORD_WIDTH-1:0]       vertex_b_row,
	input  logic signed [ELEV_WIDTH-1:0] vertex_b_elev,
	input  logic [COORD_WIDTH-1:0]       vertex_c_col,
	input  logic [COORD_WIDTH-1:0]       vertex_c_row,
	input  logic signed [ELEV_WIDTH-1:0] vertex_c_elev,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic [2:0]                   location_class,
	output logic signed [ELEV_WIDTH-1:0] estimate_elev,
	output logic [ELEV_WIDTH-2:0]        abs_error,
	output logic                         degenerate,
	output logic                         saturated
);

	localparam int NW = ELEV_WIDTH + 2 * COORD_WIDTH + 5;
	localparam int KW = 2 * COORD_WIDTH + 3;

	logic                         adv;
	logic                         fr_valid, dv_valid, bk_valid;
	logic [NW-1:0]                fr_num, dv_quo;
	logic [KW-1:0]                fr_den;
	ctl_t                         fr_ctl, dv_ctl;
	logic signed [ELEV_WIDTH-1:0] fr_az, fr_pz, dv_az, dv_pz;
	res_flags_t                   bk_flags, ob_flags;
	logic signed [ELEV_WIDTH-1:0] bk_est;
	logic [ELEV_WIDTH-2:0]        bk_err;

	assign in_stall = !adv;

	ptle_front #(
		.COORD_WIDTH (COORD_WIDTH),
		.ELEV_WIDTH  (ELEV_WIDTH)
	) u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.adv           (adv),
		.in_valid      (in_valid),
		.point_col     (point_col),
		.point_row     (point_row),
		.point_elev    (point_elev),
		.vertex_a_col  (vertex_a_col),
		.vertex_a_row  (vertex_a_row),
		.vertex_a_elev (vertex_a_elev),
		.vertex_b_col  (vertex_b_col),
		.vertex_b_row  (vertex_b_row),
		.vertex_b_elev (vertex_b_elev),
		.vertex_c_col  (vertex_c_col),
		.vertex_c_row  (vertex_c_row),
		.vertex_c_elev (vertex_c_elev),
		.out_valid     (fr_valid),
		.out_num       (fr_num),
		.out_den       (fr_den),
		.out_ctl       (fr_ctl),
		.out_az        (fr_az),
		.out_pz        (fr_pz)
	);

	ptle_div #(
		.NUM_WIDTH  (NW),
		.DEN_WIDTH  (KW),
		.ELEV_WIDTH (ELEV_WIDTH),
		.STEPS      (STEPS)
	) u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.adv       (adv),
		.in_valid  (fr_valid),
		.in_num    (fr_num),
		.in_den    (fr_den),
		.in_ctl    (fr_ctl),
		.in_az     (fr_az),
		.in_pz     (fr_pz),
		.out_valid (dv_valid),
		.out_quo   (dv_quo),
		.out_ctl   (dv_ctl),
		.out_az    (dv_az),
		.out_pz    (dv_pz)
	);

	ptle_back #(
		.NUM_WIDTH  (NW),
		.ELEV_WIDTH (ELEV_WIDTH)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.adv       (adv),
		.in_valid  (dv_valid),
		.in_quo    (dv_quo),
		.in_ctl    (dv_ctl),
		.in_az     (dv_az),
		.in_pz     (dv_pz),
		.out_valid (bk_valid),
		.out_flags (bk_flags),
		.out_est   (bk_est),
		.out_err   (bk_err)
	);

	ptle_outbuf #(
		.ELEV_WIDTH (ELEV_WIDTH)
	) u_outbuf (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (bk_valid),
		.in_flags  (bk_flags),
		.in_est    (bk_est),
		.in_err    (bk_err),
		.adv       (adv),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_flags (ob_flags),
		.out_est   (estimate_elev),
		.out_err   (abs_error)
	);

	assign location_class = ob_flags.loc;
	assign degenerate     = ob_flags.degen;
	assign saturated      = ob_flags.sat;

endmodule
`default_nettype wire

// File: tb/sv/testbench.sv
// ---------------------------------------------------------------------------
// Testbench for point_triangle_locate_and_error_top
// Drives a table of directed point and triangle queries, then random queries
// of several shapes: wide random triangles, small triangles, points on edges
// and vertices, and collinear vertex sets. Transactions without a table
// result are predicted in 64-bit arithmetic and every result is checked in
// order. Three phases of different idling and stalling, one long output
// hold and drains between phases exercise the handshakes.
// ---------------------------------------------------------------------------
module testbench;
	import ptle_pkg::*;

	localparam int CW = PTLE_COORD_WIDTH;
	localparam int EW = PTLE_ELEV_WIDTH;
	localparam int COORD_MAX = (1 << CW) - 1;
	localparam int NUM_DIRECTED = 22;
	localparam int RANDOM_PER_PHASE = 476;
	localparam int LONG_HOLD_CYCLES = 400;
	localparam int SETTLE_CYCLES = 40;
	localparam longint LIMIT_CYCLES = 400000;
	localparam longint EST_HI = (longint'(1) <<< (EW - 1)) - 1;
	localparam longint EST_LO = -EST_HI - 1;

	localparam logic signed [EW-1:0] EMAX = {1'b0, {(EW - 1){1'b1}}};
	localparam logic signed [EW-1:0] EMIN = {1'b1, {(EW - 1){1'b0}}};
	localparam logic [EW-2:0] ERR_MAX = {(EW - 1){1'b1}};

	typedef enum int {SIDE_RIGHT, SIDE_LEFT, SIDE_ON} side_t;

	typedef struct packed {
		logic [CW-1:0] pcol, prow;
		logic signed [EW-1:0] pelev;
		logic [CW-1:0] acol, arow;
		logic signed [EW-1:0] aelev;
		logic [CW-1:0] bcol, brow;
		logic signed [EW-1:0] belev;
		logic [CW-1:0] ccol, crow;
		logic signed [EW-1:0] celev;
	} tri_query_t;

	typedef struct packed {
		loc_t loc;
		logic signed [EW-1:0] est;
		logic [EW-2:0] err;
		logic degen;
		logic sat;
	} elev_result_t;

	typedef struct packed {
		tri_query_t q;
		logic has_golden;
		elev_result_t golden;
	} directed_row_t;

	localparam elev_result_t NO_RESULT = '0;

	// The first rows carry results that follow from flat planes, degenerate
	// triangles or clipping; the rest are left to the predictor.
	localparam directed_row_t DIRECTED [NUM_DIRECTED] = '{
		'{'{0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0}, 1'b1, '{LOC_EDGE_AB, 0, 0, 1'b1, 1'b0}},
		'{'{4095, 4095, EMAX, 4095, 4095, EMAX, 4095, 4095, EMIN, 4095, 4095, EMAX},
			1'b1, '{LOC_EDGE_AB, 0, 0, 1'b1, 1'b0}},
		'{'{0, 0, 100, 0, 0, 0, 4095, 0, 0, 0, 4095, 0},
			1'b1, '{LOC_EDGE_AB, 0, 100, 1'b0, 1'b0}},
		'{'{10, 10, 0, 0, 0, 256, 100, 0, 256, 0, 100, 256},
			1'b1, '{LOC_INTERIOR, 256, 256, 1'b0, 1'b0}},
		'{'{200, 200, 0, 0, 0, 256, 100, 0, 256, 0, 100, 256},
			1'b1, '{LOC_OUTSIDE, 256, 0, 1'b0, 1'b0}},
		'{'{50, 50, 256, 0, 0, 256, 100, 0, 256, 0, 100, 256},
			1'b1, '{LOC_EDGE_BC, 256, 0, 1'b0, 1'b0}},
		'{'{0, 50, -256, 0, 0, 256, 100, 0, 256, 0, 100, 256},
			1'b1, '{LOC_EDGE_CA, 256, 512, 1'b0, 1'b0}},
		'{'{200, 0, 256, 0, 0, 256, 100, 0, 256, 0, 100, 256},
			1'b1, '{LOC_OUTSIDE, 256, 0, 1'b0, 1'b0}},
		'{'{10, 10, 0, 0, 0, 0, 0, 100, 0, 100, 0, 0},
			1'b1, '{LOC_INTERIOR, 0, 0, 1'b0, 1'b0}},
		'{'{4095, 0, 0, 0, 0, EMAX, 1, 0, EMIN, 0, 1, EMAX},
			1'b1, '{LOC_OUTSIDE, EMIN, 0, 1'b0, 1'b1}},
		'{'{10, 10, EMIN, 0, 0, EMAX, 100, 0, EMAX, 0, 100, EMAX},
			1'b1, '{LOC_INTERIOR, EMAX, ERR_MAX, 1'b0, 1'b1}},
		'{'{5, 5, 777, 0, 0, 1, 10, 10, 2, 20, 20, 3},
			1'b1, '{LOC_EDGE_AB, 0, 0, 1'b1, 1'b0}},
		'{'{5, 6, 777, 0, 0, 1, 10, 10, 2, 20, 20, 3},
			1'b1, '{LOC_OUTSIDE, 0, 0, 1'b1, 1'b0}},
		'{'{1, 1, 0, 0, 0, 0, 3, 0, 100, 0, 3, -100}, 1'b0, NO_RESULT},
		'{'{2, 1, -5, 0, 0, -1, 3, 0, -100, 0, 3, 101}, 1'b0, NO_RESULT},
		'{'{4095, 4095, EMIN, 0, 0, EMAX, 4095, 0, EMIN, 4095, 4095, EMAX}, 1'b0, NO_RESULT},
		'{'{2048, 1024, EMAX, 0, 0, EMIN, 4095, 0, EMAX, 4095, 4095, EMIN}, 1'b0, NO_RESULT},
		'{'{4095, 0, -1, 0, 4095, EMAX, 4095, 4095, EMIN, 0, 0, 0}, 1'b0, NO_RESULT},
		'{'{1000, 3000, 12345, 4095, 0, -77777, 0, 4095, 88888, 0, 0, -3}, 1'b0, NO_RESULT},
		'{'{3, 1, 0, 0, 0, EMIN, 7, 2, EMAX, 1, 5, EMIN}, 1'b0, NO_RESULT},
		'{'{2047, 2048, 0, 0, 4095, 0, 4095, 0, EMAX, 4095, 4095, EMAX}, 1'b0, NO_RESULT},
		'{'{1, 1, EMAX, 0, 0, EMIN, 0, 4095, EMIN, 4095, 0, EMIN}, 1'b0, NO_RESULT}
	};

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [CW-1:0] point_col, point_row;
	logic signed [EW-1:0] point_elev;
	logic [CW-1:0] vertex_a_col, vertex_a_row;
	logic signed [EW-1:0] vertex_a_elev;
	logic [CW-1:0] vertex_b_col, vertex_b_row;
	logic signed [EW-1:0] vertex_b_elev;
	logic [CW-1:0] vertex_c_col, vertex_c_row;
	logic signed [EW-1:0] vertex_c_elev;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [2:0] location_class;
	logic signed [EW-1:0] estimate_elev;
	logic [EW-2:0] abs_error;
	logic degenerate;
	logic saturated;

	tri_query_t cur_q = '0;
	bit cur_has_golden = 1'b0;
	elev_result_t cur_golden = '0;
	elev_result_t pending_results [$];

	int unsigned send_idle_pct = 0;
	int unsigned recv_stall_pct = 0;
	int unsigned hold_trigger = 0;
	int unsigned n_in = 0;
	int unsigned n_results = 0;
	int unsigned n_bad = 0;
	int unsigned n_loc [5] = '{default: 0};
	int unsigned n_degen = 0;
	int unsigned n_sat = 0;
	longint n_cycles = 0;

	assign point_col = cur_q.pcol;
	assign point_row = cur_q.prow;
	assign point_elev = cur_q.pelev;
	assign vertex_a_col = cur_q.acol;
	assign vertex_a_row = cur_q.arow;
	assign vertex_a_elev = cur_q.aelev;
	assign vertex_b_col = cur_q.bcol;
	assign vertex_b_row = cur_q.brow;
	assign vertex_b_elev = cur_q.belev;
	assign vertex_c_col = cur_q.ccol;
	assign vertex_c_row = cur_q.crow;
	assign vertex_c_elev = cur_q.celev;

	point_triangle_locate_and_error_top i_dut (.*);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	function automatic side_t turn_side(input longint ux, uy, vx, vy, wx, wy);
		longint cr;
		cr = (vx - ux) * (wy - uy) - (wx - ux) * (vy - uy);
		if (cr > 0)
			return SIDE_LEFT;
		if (cr == 0)
			return SIDE_ON;
		return SIDE_RIGHT;
	endfunction

	function automatic bit in_bbox(input longint px, py, ux, uy, vx, vy);
		return px >= (ux < vx ? ux : vx) && px <= (ux < vx ? vx : ux) &&
			py >= (uy < vy ? uy : vy) && py <= (uy < vy ? vy : uy);
	endfunction

	// All products stay below 2^60 at these sizes, so 64-bit math is exact.
	function automatic elev_result_t interpolate_point(input tri_query_t q);
		longint px, py, pz, ax, ay, az, bx, by, bz, cx, cy, cz;
		longint v1x, v1y, v1z, v2x, v2y, v2z, k, s, full, gap;
		side_t e1, e2, e3;
		elev_result_t r;
		px = longint'(q.pcol);
		py = longint'(q.prow);
		pz = longint'($signed(q.pelev));
		ax = longint'(q.acol);
		ay = longint'(q.arow);
		az = longint'($signed(q.aelev));
		bx = longint'(q.bcol);
		by = longint'(q.brow);
		bz = longint'($signed(q.belev));
		cx = longint'(q.ccol);
		cy = longint'(q.crow);
		cz = longint'($signed(q.celev));
		e1 = turn_side(ax, ay, bx, by, px, py);
		e2 = turn_side(bx, by, cx, cy, px, py);
		e3 = turn_side(cx, cy, ax, ay, px, py);
		r = NO_RESULT;
		if (e1 == e2 && e1 == e3 && e1 != SIDE_ON)
			r.loc = LOC_INTERIOR;
		else if (e1 == SIDE_ON && in_bbox(px, py, ax, ay, bx, by))
			r.loc = LOC_EDGE_AB;
		else if (e2 == SIDE_ON && in_bbox(px, py, bx, by, cx, cy))
			r.loc = LOC_EDGE_BC;
		else if (e3 == SIDE_ON && in_bbox(px, py, cx, cy, ax, ay))
			r.loc = LOC_EDGE_CA;
		v1x = bx - ax;
		v1y = by - ay;
		v1z = bz - az;
		v2x = cx - ax;
		v2y = cy - ay;
		v2z = cz - az;
		k = v1x * v2y - v1y * v2x;
		if (k == 0) begin
			r.degen = 1'b1;
			return r;
		end
		s = v2z * (v1y * (px - ax) - v1x * (py - ay)) + v1z * (v2x * (py - ay) - v2y * (px - ax));
		full = az - s / k;
		if (full > EST_HI) begin
			r.est = EMAX;
			r.sat = 1'b1;
		end else if (full < EST_LO) begin
			r.est = EMIN;
			r.sat = 1'b1;
		end else begin
			r.est = full[EW-1:0];
		end
		if (r.loc != LOC_OUTSIDE) begin
			gap = full - pz;
			if (gap < 0)
				gap = -gap;
			if (gap > EST_HI) begin
				r.err = ERR_MAX;
				r.sat = 1'b1;
			end else begin
				r.err = gap[EW-2:0];
			end
		end
		return r;
	endfunction

	function automatic int rand_coord();
		int unsigned sel;
		sel = $urandom_range(9);
		if (sel == 0)
			return 0;
		if (sel == 1)
			return COORD_MAX;
		return int'($urandom_range(COORD_MAX));
	endfunction

	function automatic logic signed [EW-1:0] rand_elev();
		int unsigned sel;
		sel = $urandom_range(9);
		if (sel < 3)
			return $urandom();
		if (sel == 3)
			return EMAX - $urandom_range(3);
		if (sel == 4)
			return EMIN + $urandom_range(3);
		return $urandom_range(20000) - 10000;
	endfunction

	function automatic tri_query_t random_query();
		int xs [4];
		int ys [4];
		int ox, oy, sx, sy, steps, span, role, m, i;
		int unsigned pick;
		tri_query_t q;
		elev_result_t r;
		pick = $urandom_range(99);
		ox = $urandom_range(200, 3895);
		oy = $urandom_range(200, 3895);
		sx = int'($urandom_range(30)) - 15;
		sy = int'($urandom_range(30)) - 15;
		if (sx == 0 && sy == 0)
			sx = 1;
		steps = $urandom_range(1, 12);
		if (pick < 15) begin
			for (i = 0; i < 4; i++) begin
				xs[i] = rand_coord();
				ys[i] = rand_coord();
			end
		end else if (pick < 55 || pick >= 88) begin
			span = ($urandom_range(9) == 0) ? COORD_MAX : int'($urandom_range(2, 64));
			ox = $urandom_range(COORD_MAX - span);
			oy = $urandom_range(COORD_MAX - span);
			for (i = 0; i < 4; i++) begin
				xs[i] = ox + int'($urandom_range(span));
				ys[i] = oy + int'($urandom_range(span));
			end
			if (pick >= 88) begin
				i = $urandom_range(1, 3);
				xs[0] = xs[i];
				ys[0] = ys[i];
			end
		end else if (pick < 78) begin
			role = $urandom_range(2);
			m = $urandom_range(steps);
			xs[0] = ox + m * sx;
			ys[0] = oy + m * sy;
			xs[1 + role] = ox;
			ys[1 + role] = oy;
			xs[1 + (role + 1) % 3] = ox + steps * sx;
			ys[1 + (role + 1) % 3] = oy + steps * sy;
			xs[1 + (role + 2) % 3] = ox + int'($urandom_range(60)) - 30;
			ys[1 + (role + 2) % 3] = oy + int'($urandom_range(60)) - 30;
		end else begin
			for (i = 0; i < 4; i++) begin
				m = $urandom_range(steps);
				xs[i] = ox + m * sx;
				ys[i] = oy + m * sy;
			end
			if ($urandom_range(3) == 0)
				xs[0] = xs[0] + 1;
		end
		q.pcol = xs[0][CW-1:0];
		q.prow = ys[0][CW-1:0];
		q.acol = xs[1][CW-1:0];
		q.arow = ys[1][CW-1:0];
		q.bcol = xs[2][CW-1:0];
		q.brow = ys[2][CW-1:0];
		q.ccol = xs[3][CW-1:0];
		q.crow = ys[3][CW-1:0];
		q.pelev = rand_elev();
		q.aelev = rand_elev();
		q.belev = rand_elev();
		q.celev = rand_elev();
		// Keep the measured elevation near the plane now and then, so that
		// small errors show up as often as clipped ones.
		if ($urandom_range(2) == 0) begin
			r = interpolate_point(q);
			if (!r.degen)
				q.pelev = r.est + (int'($urandom_range(512)) - 256);
		end
		return q;
	endfunction

	task automatic offer(input tri_query_t q, input bit has_golden, input elev_result_t golden);
		while ($urandom_range(99) < send_idle_pct) begin
			@(negedge clk);
			in_valid = 1'b0;
		end
		@(negedge clk);
		cur_q = q;
		cur_has_golden = has_golden;
		cur_golden = golden;
		in_valid = 1'b1;
		do
			@(posedge clk);
		while (in_stall);
	endtask

	task automatic drain();
		@(negedge clk);
		in_valid = 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
	endtask

	initial begin : receiver
		int hold_left;
		bit held;
		hold_left = 0;
		held = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_left > 0) begin
				hold_left--;
				out_stall = 1'b1;
			end else if (!held && hold_trigger != 0 && n_in >= hold_trigger) begin
				held = 1'b1;
				hold_left = LONG_HOLD_CYCLES - 1;
				out_stall = 1'b1;
			end else begin
				out_stall = ($urandom_range(99) < recv_stall_pct);
			end
		end
	end

	always @(posedge clk) begin : scoreboard
		elev_result_t got, want;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				got.loc = loc_t'(location_class);
				got.est = estimate_elev;
				got.err = abs_error;
				got.degen = degenerate;
				got.sat = saturated;
				if (pending_results.size() == 0) begin
					n_bad++;
					if (n_bad <= 10)
						$display("Unexpected result: class %0d est %0d err %0d degen %0b sat %0b.",
							got.loc, $signed(got.est), got.err, got.degen, got.sat);
				end else begin
					want = pending_results.pop_front();
					n_results++;
					n_loc[int'(want.loc)]++;
					n_degen += want.degen;
					n_sat += want.sat;
					if (got.loc !== want.loc || got.est !== want.est || got.err !== want.err ||
						got.degen !== want.degen || got.sat !== want.sat) begin
						n_bad++;
						if (n_bad <= 10) begin
							$display("Result %0d mismatch: class %0d/%0d est %0d/%0d",
								n_results, want.loc, got.loc, $signed(want.est),
								$signed(got.est));
							$display("  err %0d/%0d degen %0b/%0b sat %0b/%0b (expected/actual).",
								want.err, got.err, want.degen, got.degen, want.sat, got.sat);
						end
					end
				end
			end
			if (in_valid && !in_stall) begin
				pending_results.push_back(cur_has_golden ? cur_golden : interpolate_point(cur_q));
				n_in++;
			end
		end
	end

	always @(posedge clk) begin : watchdog
		n_cycles++;
		if (n_cycles > LIMIT_CYCLES) begin
			$display("point_triangle_locate_and_error_top test failed");
			$finish;
		end
	end

	initial begin : stimulus
		int i, phase;
		repeat (9)
			@(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		send_idle_pct = 6;
		recv_stall_pct = 78;
		for (i = 0; i < NUM_DIRECTED; i++)
			offer(DIRECTED[i].q, DIRECTED[i].has_golden, DIRECTED[i].golden);
		for (phase = 0; phase < 3; phase++) begin
			drain();
			send_idle_pct = (phase == 1) ? 78 : (phase == 0 ? 6 : 0);
			recv_stall_pct = (phase == 0) ? 78 : (phase == 1 ? 6 : 0);
			// With no idling the output is held once for a long stretch, so
			// the pipeline fills and pushes back on the input.
			if (phase == 2)
				hold_trigger = n_in + 100;
			for (i = 0; i < RANDOM_PER_PHASE; i++)
				offer(random_query(), 1'b0, NO_RESULT);
		end
		drain();
		repeat (SETTLE_CYCLES)
			@(posedge clk);
		$display("Checked %0d results of %0d transactions: %0d interior, %0d on an edge, %0d outside.",
			n_results, n_in, n_loc[1], n_loc[2] + n_loc[3] + n_loc[4], n_loc[0]);
		$display("Degenerate triangles: %0d, saturated results: %0d, mismatches: %0d.",
			n_degen, n_sat, n_bad);
		if (n_bad == 0 && pending_results.size() == 0)
			$display("point_triangle_locate_and_error_top test passed");
		else
			$display("point_triangle_locate_and_error_top test failed");
		$finish;
	end

endmodule
